// ===== design/fsp_pkg.sv =====
package fsp_pkg;

    // parser phase
    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_FLAGS = 2'd1,
        PH_WIDTH = 2'd2,
        PH_PREC  = 2'd3
    } t_phase;

    // flag bit positions
    localparam int unsigned FL_LEFT  = 0;
    localparam int unsigned FL_ZERO  = 1;
    localparam int unsigned FL_HASH  = 2;
    localparam int unsigned FL_SPACE = 3;
    localparam int unsigned FL_PLUS  = 4;
    localparam int unsigned FL_COUNT = 5;

    // character codes
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_LC_C    = 8'h63;
    localparam logic [7:0] CH_LC_S    = 8'h73;
    localparam logic [7:0] CH_LC_D    = 8'h64;
    localparam logic [7:0] CH_LC_I    = 8'h69;
    localparam logic [7:0] CH_LC_U    = 8'h75;
    localparam logic [7:0] CH_LC_X    = 8'h78;
    localparam logic [7:0] CH_UC_X    = 8'h58;
    localparam logic [7:0] CH_LC_P    = 8'h70;

    localparam int unsigned FIELD_W = 16;

    // input transaction
    typedef struct packed {
        logic [7:0] ch;
    } t_fsp_in;

    // result transaction
    typedef struct packed {
        logic [7:0]         conversion;
        logic               left_align;
        logic               zero_pad;
        logic               alt_prefix;
        logic               space_sign;
        logic               plus_sign;
        logic               width_given;
        logic [FIELD_W-1:0] field_width;
        logic               prec_given;
        logic [FIELD_W-1:0] prec_value;
    } t_fsp_out;

    // flag character to flag mask, zero when not a flag
    function automatic logic [FL_COUNT-1:0] flag_of(input logic [7:0] c);
        logic [FL_COUNT-1:0] m;
        m = '0;
        case (c)
            CH_MINUS: m[FL_LEFT]  = 1'b1;
            CH_ZERO:  m[FL_ZERO]  = 1'b1;
            CH_HASH:  m[FL_HASH]  = 1'b1;
            CH_SPACE: m[FL_SPACE] = 1'b1;
            CH_PLUS:  m[FL_PLUS]  = 1'b1;
            default:  m = '0;
        endcase
        return m;
    endfunction

    // known conversion letters
    function automatic logic is_conv(input logic [7:0] c);
        return (c == CH_LC_C) || (c == CH_LC_S) || (c == CH_LC_D) ||
               (c == CH_LC_I) || (c == CH_LC_U) || (c == CH_LC_X) ||
               (c == CH_UC_X) || (c == CH_LC_P);
    endfunction

endpackage

// ===== design/fsp_stream_if.sv =====
interface fsp_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/fsp_acc.sv =====
module fsp_acc #(
    parameter int unsigned ACC_W = 16
) (
    input  logic [ACC_W-1:0] i_acc,
    input  logic             i_restart,
    input  logic [3:0]       i_digit,
    output logic [ACC_W-1:0] o_sum
);
    logic [ACC_W+3:0] base;
    logic [ACC_W+3:0] sum;

    // times ten plus digit, saturating at all ones
    always_comb begin
        base = i_restart ? '0 : (ACC_W+4)'(i_acc);
        sum  = (base << 3) + (base << 1) + (ACC_W+4)'(i_digit);
        if (|sum[ACC_W+3:ACC_W]) begin
            o_sum = '1;
        end else begin
            o_sum = sum[ACC_W-1:0];
        end
    end
endmodule

// ===== design/format_spec_parser.sv =====
// channel  direction  payload     handshake
// i_in     sink       t_fsp_in    valid / ready
// o_out    source     t_fsp_out   valid / ready
//
// one character per cycle sustained unless an offered result is stalled; a result is
// offered after its terminating character is accepted (input register, then result register)
// the step logic is one decode and one times-ten accumulate per character
// synchronous active-low reset returns the parser to the start of a specifier
// a stalled result holds the step; the input register still takes one more
module format_spec_parser
    import fsp_pkg::*;
#(
    parameter int unsigned NUM_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fsp_stream_if.sink           i_in,
    fsp_stream_if.source         o_out
);
    localparam int unsigned ACC_W = (NUM_BITS < FIELD_W) ? NUM_BITS : FIELD_W;

    // input register
    logic       r_in_valid;
    logic [7:0] r_ch;

    // parser state
    t_phase              r_phase, n_phase, s_phase;
    logic [FL_COUNT-1:0] r_flags, n_flags, s_flags;
    logic [ACC_W-1:0]    r_width_acc, n_width_acc, s_width_acc;
    logic                r_width_seen, n_width_seen, s_width_seen;
    logic [ACC_W-1:0]    r_prec_acc, n_prec_acc, s_prec_acc;
    logic                r_prec_seen, n_prec_seen, s_prec_seen;

    // result register
    logic     r_out_valid;
    t_fsp_out r_out;
    t_fsp_out n_out;

    logic                advance;
    logic                emit;
    logic                is_digit;
    logic                is_dot;
    logic [FL_COUNT-1:0] fmask;
    logic [ACC_W-1:0]    width_sum;
    logic [ACC_W-1:0]    prec_sum;
    logic                signed_conv;
    logic                keep_prec;

    assign advance  = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    // character decode
    assign is_digit = (r_ch >= CH_ZERO) && (r_ch <= CH_NINE);
    assign is_dot   = (r_ch == CH_DOT);
    assign fmask    = flag_of(r_ch);

    // digit accumulators
    fsp_acc #(.ACC_W(ACC_W)) u_width_acc (
        .i_acc     (r_width_acc),
        .i_restart (r_phase != PH_WIDTH),
        .i_digit   (r_ch[3:0]),
        .o_sum     (width_sum)
    );

    fsp_acc #(.ACC_W(ACC_W)) u_prec_acc (
        .i_acc     (r_prec_acc),
        .i_restart (1'b0),
        .i_digit   (r_ch[3:0]),
        .o_sum     (prec_sum)
    );

    // next state, before the return to start on a result
    always_comb begin
        s_phase      = r_phase;
        s_flags      = r_flags;
        s_width_acc  = r_width_acc;
        s_width_seen = r_width_seen;
        s_prec_acc   = r_prec_acc;
        s_prec_seen  = r_prec_seen;
        emit         = 1'b0;
        case (r_phase)
            PH_START, PH_FLAGS: begin
                if (r_phase == PH_START && r_ch == CH_PERCENT) begin
                    emit = 1'b1;
                end else if (|fmask) begin
                    s_flags = r_flags | fmask;
                    s_phase = PH_FLAGS;
                end else if (is_dot) begin
                    s_flags[FL_ZERO] = 1'b0;
                    s_prec_seen      = 1'b1;
                    s_prec_acc       = '0;
                    s_phase          = PH_PREC;
                end else if (is_conv(r_ch)) begin
                    emit = 1'b1;
                end else begin
                    s_width_seen = 1'b1;
                    if (is_digit) begin
                        s_width_acc = width_sum;
                        s_phase     = PH_WIDTH;
                    end else begin
                        s_width_acc = '0;
                        emit        = 1'b1;
                    end
                end
            end
            PH_WIDTH: begin
                if (is_digit) begin
                    s_width_acc = width_sum;
                end else if (is_dot) begin
                    s_flags[FL_ZERO] = 1'b0;
                    s_prec_seen      = 1'b1;
                    s_prec_acc       = '0;
                    s_phase          = PH_PREC;
                end else begin
                    emit = 1'b1;
                end
            end
            PH_PREC: begin
                if (is_digit) begin
                    s_prec_acc = prec_sum;
                end else begin
                    emit = 1'b1;
                end
            end
            default: begin
                emit = 1'b1;
            end
        endcase
    end

    // a result sends the parser back to the start of a specifier
    always_comb begin
        if (emit) begin
            n_phase      = PH_START;
            n_flags      = '0;
            n_width_acc  = '0;
            n_width_seen = 1'b0;
            n_prec_acc   = '0;
            n_prec_seen  = 1'b0;
        end else begin
            n_phase      = s_phase;
            n_flags      = s_flags;
            n_width_acc  = s_width_acc;
            n_width_seen = s_width_seen;
            n_prec_acc   = s_prec_acc;
            n_prec_seen  = s_prec_seen;
        end
    end

    // normalized rule set
    always_comb begin
        signed_conv = (r_ch == CH_LC_D) || (r_ch == CH_LC_I);
        keep_prec   = s_prec_seen && (r_ch != CH_LC_P) && (r_ch != CH_LC_C);

        n_out.conversion  = r_ch;
        n_out.left_align  = s_flags[FL_LEFT];
        n_out.zero_pad    = s_flags[FL_ZERO] && !s_flags[FL_LEFT] && !s_prec_seen;
        n_out.alt_prefix  = (r_ch == CH_LC_P) ||
                            (((r_ch == CH_LC_X) || (r_ch == CH_UC_X)) && s_flags[FL_HASH]);
        n_out.plus_sign   = signed_conv && s_flags[FL_PLUS];
        n_out.space_sign  = signed_conv && !s_flags[FL_PLUS] && s_flags[FL_SPACE];
        n_out.width_given = s_width_seen;
        n_out.field_width = s_width_seen ? FIELD_W'(s_width_acc) : '0;
        n_out.prec_given  = keep_prec;
        n_out.prec_value  = keep_prec ? FIELD_W'(s_prec_acc) : '0;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_ch <= i_in.payload.ch;
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_flags      <= '0;
            r_width_acc  <= '0;
            r_width_seen <= 1'b0;
            r_prec_acc   <= '0;
            r_prec_seen  <= 1'b0;
        end else if (advance) begin
            r_phase      <= n_phase;
            r_flags      <= n_flags;
            r_width_acc  <= n_width_acc;
            r_width_seen <= n_width_seen;
            r_prec_acc   <= n_prec_acc;
            r_prec_seen  <= n_prec_seen;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && emit) begin
            r_out <= n_out;
        end
    end
endmodule
